@@ design/assert_macros.svh @@
// assertion macros shared by the coin mix hill climber modules
// no dependencies; included by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CMHC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CMHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/cmhc_pkg.sv @@
// shared constants, command/status structs and cost function
// for the coin mix hill climber; no dependencies
`timescale 1ns / 1ps

package cmhc_pkg;

	localparam int MAX_TYPES  = 16;
	localparam int IDX_W      = 4;
	localparam int PTR_W      = 5;
	localparam int COUNT_BITS = 16;
	localparam int VAL_W      = 16;
	localparam int SUM_W      = 36;
	localparam int TOT_W      = 21;
	localparam int COST_W     = 32;
	localparam int TGT_W      = 24;
	localparam int NT_W       = 5;
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam int QUOT_W     = 17;
	localparam int PROD_W     = 32;
	localparam int DIV_CNT_W  = 5;
	localparam int COST_EXT_W = SUM_W + 5;

	localparam logic [COST_EXT_W-1:0] COST_BASE = COST_EXT_W'(10000);

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_TYPES = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 3'd0,
		OP_INC  = 3'd1,
		OP_DEC  = 3'd2,
		OP_SWAP = 3'd3,
		OP_READ = 3'd4
	} op_t;

	typedef struct packed {
		logic capture;
		logic load_wr;
		logic copy;
		logic nb_inc;
		logic nb_dec;
		logic swap_rd;
		logic swap_wa;
		logic swap_wb;
		logic sum_step;
		logic rep_init;
		logic rep_skip;
		logic div_start;
		logic rep_apply;
		logic cost_calc;
		logic decide;
		logic recompute;
		logic emit;
		logic emit_read;
	} dp_cmd_t;

	typedef struct packed {
		logic sum_done;
		logic rep_more;
		logic nbj_zero;
		logic val_zero;
		logic div_done;
		logic out_free;
		logic rd_last;
	} dp_stat_t;

	// exact match costs the coin total, else a 10000 penalty plus the total plus ten times the miss
	function automatic logic [COST_W-1:0] cost_of(input logic [SUM_W-1:0] sum,
			input logic [TOT_W-1:0] tot, input logic [TGT_W-1:0] tgt);
		logic [SUM_W-1:0]      t;
		logic [SUM_W-1:0]      d;
		logic [COST_EXT_W-1:0] c;
		t = SUM_W'(tgt);
		if (sum == t) begin
			c = COST_EXT_W'(tot);
		end else begin
			d = (sum > t) ? (sum - t) : (t - sum);
			c = COST_BASE + COST_EXT_W'(tot) + (COST_EXT_W'(d) << 3) + (COST_EXT_W'(d) << 1);
		end
		if (c[COST_EXT_W-1:COST_W] != '0) begin
			return '1;
		end
		return c[COST_W-1:0];
	endfunction

endpackage

@@ design/cmhc_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// uses cmhc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmhc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cmhc_pkg::SUM_W-1:0]     dividend,
	input  logic [cmhc_pkg::VAL_W-1:0]     divisor,
	output logic                           done,
	output logic [cmhc_pkg::QUOT_W-1:0]    quot,
	output logic                           over
);

	logic                              run_q;
	logic                              done_q;
	logic [cmhc_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [cmhc_pkg::VAL_W-1:0]        rem_q;
	logic [cmhc_pkg::VAL_W-1:0]        dsr_q;
	logic [cmhc_pkg::QUOT_W-1:0]       dvd_q;
	logic [cmhc_pkg::QUOT_W-1:0]       quot_q;
	logic                              over_q;
	logic [cmhc_pkg::VAL_W:0]          r2;
	logic [cmhc_pkg::VAL_W:0]          r_sub;
	logic                              ge;

	assign r2    = {rem_q, dvd_q[cmhc_pkg::QUOT_W-1]};
	assign ge    = r2 >= {1'b0, dsr_q};
	assign r_sub = r2 - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmhc_pkg::DIV_CNT_W'(cmhc_pkg::QUOT_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - cmhc_pkg::DIV_CNT_W'(1);
			if (cnt_q == cmhc_pkg::DIV_CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient that does not fit is flagged and capped later
			over_q <= dividend[cmhc_pkg::SUM_W-1:cmhc_pkg::QUOT_W] >=
				(cmhc_pkg::SUM_W - cmhc_pkg::QUOT_W)'(divisor);
			rem_q  <= dividend[cmhc_pkg::QUOT_W+cmhc_pkg::VAL_W-1:cmhc_pkg::QUOT_W];
			dvd_q  <= dividend[cmhc_pkg::QUOT_W-1:0];
			dsr_q  <= divisor;
		end else if (run_q) begin
			rem_q  <= ge ? r_sub[cmhc_pkg::VAL_W-1:0] : r2[cmhc_pkg::VAL_W-1:0];
			quot_q <= {quot_q[cmhc_pkg::QUOT_W-2:0], ge};
			dvd_q  <= dvd_q << 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign over = over_q;

	`CMHC_ASSERT_NOW(a_no_restart, clk, arst_n, start, !run_q, "divider restarted while busy")
	`CMHC_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "divider done held over")

endmodule

@@ design/cmhc_dp.sv @@
// datapath: coin tables, neighbor counts, sum and cost, result register
// uses cmhc_pkg, cmhc_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmhc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [cmhc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cmhc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [cmhc_pkg::IDX_W-1:0]          index_a,
	input  logic [cmhc_pkg::IDX_W-1:0]          index_b,
	input  logic [cmhc_pkg::VAL_W-1:0]          coin_value,
	input  logic [cmhc_pkg::COUNT_BITS-1:0]     start_count,
	input  cmhc_pkg::dp_cmd_t                   cmd,
	output cmhc_pkg::dp_stat_t                  stat,
	input  logic                                result_ready,
	output logic                                result_valid,
	output logic                                accepted,
	output logic [cmhc_pkg::COST_W-1:0]         best_cost,
	output logic [cmhc_pkg::IDX_W-1:0]          out_index,
	output logic [cmhc_pkg::COUNT_BITS-1:0]     out_count,
	output logic                                last
);

	logic [cmhc_pkg::TGT_W-1:0]       target_q;
	logic [cmhc_pkg::NT_W-1:0]        num_types_q;
	logic [cmhc_pkg::VAL_W-1:0]       values_q [cmhc_pkg::MAX_TYPES];
	logic [cmhc_pkg::COUNT_BITS-1:0]  counts_q [cmhc_pkg::MAX_TYPES];
	logic [cmhc_pkg::COUNT_BITS-1:0]  nb_q     [cmhc_pkg::MAX_TYPES];
	logic [cmhc_pkg::COST_W-1:0]      best_q;
	logic [cmhc_pkg::COST_W-1:0]      cost_q;
	logic [cmhc_pkg::SUM_W-1:0]       sum_q;
	logic [cmhc_pkg::TOT_W-1:0]       tot_q;
	logic [cmhc_pkg::IDX_W-1:0]       a_q;
	logic [cmhc_pkg::IDX_W-1:0]       b_q;
	logic [cmhc_pkg::VAL_W-1:0]       val_in_q;
	logic [cmhc_pkg::COUNT_BITS-1:0]  cnt_in_q;
	logic [cmhc_pkg::COUNT_BITS-1:0]  tmp_q;
	logic [cmhc_pkg::PTR_W-1:0]       ptr_q;
	logic                             acc_q;
	logic                             res_valid_q;
	logic                             res_acc_q;
	logic [cmhc_pkg::COST_W-1:0]      res_best_q;
	logic [cmhc_pkg::IDX_W-1:0]       res_idx_q;
	logic [cmhc_pkg::COUNT_BITS-1:0]  res_cnt_q;
	logic                             res_last_q;

	logic [cmhc_pkg::PTR_W-1:0]       n_use;
	logic [cmhc_pkg::PTR_W-1:0]       n_rd;
	logic [cmhc_pkg::PTR_W-1:0]       ptr_m1;
	logic [cmhc_pkg::IDX_W-1:0]       j_idx;
	logic [cmhc_pkg::IDX_W-1:0]       p_idx;
	logic [cmhc_pkg::COUNT_BITS-1:0]  nb_j;
	logic [cmhc_pkg::VAL_W-1:0]       val_j;
	logic                             a_in;
	logic                             b_in;
	logic                             sum_gt;
	logic [cmhc_pkg::SUM_W-1:0]       excess;
	logic [cmhc_pkg::SUM_W-1:0]       div_dividend;
	logic                             div_done;
	logic [cmhc_pkg::QUOT_W-1:0]      div_quot;
	logic                             div_over;
	logic [cmhc_pkg::QUOT_W:0]        q1;
	logic [cmhc_pkg::COUNT_BITS-1:0]  k;
	logic [cmhc_pkg::PROD_W-1:0]      rep_prod;
	logic [cmhc_pkg::PROD_W-1:0]      sum_prod;
	logic                             nb_we;
	logic [cmhc_pkg::IDX_W-1:0]       nb_wi;
	logic [cmhc_pkg::COUNT_BITS-1:0]  nb_wd;
	logic                             rd_last;

	assign n_use  = (num_types_q > cmhc_pkg::PTR_W'(cmhc_pkg::MAX_TYPES)) ?
		cmhc_pkg::PTR_W'(cmhc_pkg::MAX_TYPES) : num_types_q;
	assign n_rd   = (n_use == '0) ? cmhc_pkg::PTR_W'(1) : n_use;
	assign ptr_m1 = ptr_q - cmhc_pkg::PTR_W'(1);
	assign j_idx  = ptr_m1[cmhc_pkg::IDX_W-1:0];
	assign p_idx  = ptr_q[cmhc_pkg::IDX_W-1:0];
	assign nb_j   = nb_q[j_idx];
	assign val_j  = values_q[j_idx];
	assign a_in   = {1'b0, a_q} < n_use;
	assign b_in   = {1'b0, b_q} < n_use;
	assign sum_gt = sum_q > cmhc_pkg::SUM_W'(target_q);
	assign excess = sum_q - cmhc_pkg::SUM_W'(target_q);
	// ceil(ex / v) is floor((ex - 1) / v) + 1 since ex is at least one here
	assign div_dividend = excess - cmhc_pkg::SUM_W'(1);
	assign rd_last = (ptr_q + cmhc_pkg::PTR_W'(1)) == n_rd;

	cmhc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (val_j),
		.done     (div_done),
		.quot     (div_quot),
		.over     (div_over)
	);

	// coins taken from the current type, capped at what it holds
	always_comb begin
		q1 = {1'b0, div_quot} + (cmhc_pkg::QUOT_W + 1)'(1);
		if (val_j == '0 || div_over || q1 > (cmhc_pkg::QUOT_W + 1)'(nb_j)) begin
			k = nb_j;
		end else begin
			k = q1[cmhc_pkg::COUNT_BITS-1:0];
		end
	end

	assign rep_prod = cmhc_pkg::PROD_W'(k) * cmhc_pkg::PROD_W'(val_j);
	assign sum_prod = cmhc_pkg::PROD_W'(nb_q[p_idx]) * cmhc_pkg::PROD_W'(values_q[p_idx]);

	always_comb begin
		nb_we = 1'b0;
		nb_wi = a_q;
		nb_wd = nb_q[a_q];
		if (cmd.nb_inc && a_in && nb_q[a_q] != '1) begin
			nb_we = 1'b1;
			nb_wd = nb_q[a_q] + cmhc_pkg::COUNT_BITS'(1);
		end else if (cmd.nb_dec && a_in && nb_q[a_q] != '0) begin
			nb_we = 1'b1;
			nb_wd = nb_q[a_q] - cmhc_pkg::COUNT_BITS'(1);
		end else if (cmd.swap_wa && a_in && b_in && a_q != b_q) begin
			nb_we = 1'b1;
			nb_wd = nb_q[b_q];
		end else if (cmd.swap_wb && a_in && b_in && a_q != b_q) begin
			nb_we = 1'b1;
			nb_wi = b_q;
			nb_wd = tmp_q;
		end else if (cmd.rep_apply) begin
			nb_we = 1'b1;
			nb_wi = j_idx;
			nb_wd = nb_j - k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			num_types_q <= cmhc_pkg::NT_W'(1);
			best_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < cmhc_pkg::MAX_TYPES; i++) begin
				values_q[i] <= '0;
				counts_q[i] <= '0;
			end
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					cmhc_pkg::CFG_TARGET: begin
						target_q <= cfg_data[cmhc_pkg::TGT_W-1:0];
					end
					cmhc_pkg::CFG_NUM_TYPES: begin
						num_types_q <= cfg_data[cmhc_pkg::NT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_wr) begin
				values_q[a_q] <= val_in_q;
				counts_q[a_q] <= cnt_in_q;
			end
			if (cmd.decide) begin
				if (cmd.recompute) begin
					best_q <= cost_q;
				end else if (cost_q < best_q) begin
					best_q <= cost_q;
					for (int i = 0; i < cmhc_pkg::MAX_TYPES; i++) begin
						counts_q[i] <= nb_q[i];
					end
				end
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q      <= index_a;
			b_q      <= index_b;
			val_in_q <= coin_value;
			cnt_in_q <= start_count;
			acc_q    <= 1'b0;
			ptr_q    <= '0;
		end
		if (cmd.copy) begin
			for (int i = 0; i < cmhc_pkg::MAX_TYPES; i++) begin
				nb_q[i] <= counts_q[i];
			end
			sum_q <= '0;
			tot_q <= '0;
			ptr_q <= '0;
		end else if (nb_we) begin
			nb_q[nb_wi] <= nb_wd;
		end
		if (cmd.swap_rd) begin
			tmp_q <= nb_q[a_q];
		end
		if (cmd.sum_step) begin
			sum_q <= sum_q + cmhc_pkg::SUM_W'(sum_prod);
			tot_q <= tot_q + cmhc_pkg::TOT_W'(nb_q[p_idx]);
			ptr_q <= ptr_q + cmhc_pkg::PTR_W'(1);
		end
		if (cmd.rep_init) begin
			ptr_q <= n_use;
		end
		if (cmd.rep_skip) begin
			ptr_q <= ptr_m1;
		end
		if (cmd.rep_apply) begin
			sum_q <= sum_q - cmhc_pkg::SUM_W'(rep_prod);
			tot_q <= tot_q - cmhc_pkg::TOT_W'(k);
			ptr_q <= ptr_m1;
		end
		if (cmd.cost_calc) begin
			cost_q <= cmhc_pkg::cost_of(sum_q, tot_q, target_q);
		end
		if (cmd.decide && !cmd.recompute && cost_q < best_q) begin
			acc_q <= 1'b1;
		end
		if (cmd.emit) begin
			res_best_q <= best_q;
			if (cmd.emit_read) begin
				res_acc_q  <= 1'b0;
				res_idx_q  <= p_idx;
				res_cnt_q  <= counts_q[p_idx];
				res_last_q <= rd_last;
				ptr_q      <= ptr_q + cmhc_pkg::PTR_W'(1);
			end else begin
				res_acc_q  <= acc_q;
				res_idx_q  <= '0;
				res_cnt_q  <= '0;
				res_last_q <= 1'b1;
			end
		end
	end

	assign stat.sum_done = ptr_q == n_use;
	assign stat.rep_more = (ptr_q != '0) && sum_gt;
	assign stat.nbj_zero = nb_j == '0;
	assign stat.val_zero = val_j == '0;
	assign stat.div_done = div_done;
	assign stat.out_free = !res_valid_q || result_ready;
	assign stat.rd_last  = rd_last;

	assign result_valid = res_valid_q;
	assign accepted     = res_acc_q;
	assign best_cost    = res_best_q;
	assign out_index    = res_idx_q;
	assign out_count    = res_cnt_q;
	assign last         = res_last_q;

	`CMHC_ASSERT_NOW(a_div_nonzero, clk, arst_n, cmd.div_start, val_j != '0, "divide by zero coin value")

endmodule

@@ design/cmhc_ctrl.sv @@
// controller state machine sequencing load, move, repair, cost and readout
// uses cmhc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmhc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic                          item_valid,
	input  logic [cmhc_pkg::OP_W-1:0]     operation,
	output logic                          item_ready,
	input  cmhc_pkg::dp_stat_t            stat,
	output cmhc_pkg::dp_cmd_t             cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_COPY,
		S_SW1,
		S_SW2,
		S_SW3,
		S_APPLY,
		S_SUM,
		S_REP_INIT,
		S_REP_CHK,
		S_REP_DIV,
		S_COST,
		S_DECIDE,
		S_EMIT,
		S_READ
	} state_t;

	typedef enum logic [1:0] {
		K_CFG,
		K_LOAD,
		K_MOVE
	} kind_t;

	state_t                       state_q;
	kind_t                        kind_q;
	logic [cmhc_pkg::OP_W-1:0]    op_q;

	assign item_ready = (state_q == S_IDLE) && !cfg_write_en;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:     cmd.capture  = item_valid && item_ready;
			S_LOAD:     cmd.load_wr  = 1'b1;
			S_COPY:     cmd.copy     = 1'b1;
			S_SW1:      cmd.swap_rd  = 1'b1;
			S_SW2:      cmd.swap_wa  = 1'b1;
			S_SW3:      cmd.swap_wb  = 1'b1;
			S_APPLY: begin
				cmd.nb_inc = op_q == cmhc_pkg::OP_INC;
				cmd.nb_dec = op_q == cmhc_pkg::OP_DEC;
			end
			S_SUM:      cmd.sum_step = !stat.sum_done;
			S_REP_INIT: cmd.rep_init = 1'b1;
			S_REP_CHK: begin
				if (stat.rep_more) begin
					if (stat.nbj_zero) begin
						cmd.rep_skip = 1'b1;
					end else if (stat.val_zero) begin
						cmd.rep_apply = 1'b1;
					end else begin
						cmd.div_start = 1'b1;
					end
				end
			end
			S_REP_DIV:  cmd.rep_apply = stat.div_done;
			S_COST:     cmd.cost_calc = 1'b1;
			S_DECIDE: begin
				cmd.decide    = 1'b1;
				cmd.recompute = kind_q != K_MOVE;
			end
			S_EMIT:     cmd.emit = stat.out_free;
			S_READ: begin
				cmd.emit      = stat.out_free;
				cmd.emit_read = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_CFG;
			op_q    <= '0;
		end else if (cfg_write_en) begin
			// new register value: rebuild sum and cost from the counts
			state_q <= S_COPY;
			kind_q  <= K_CFG;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q <= operation;
						case (operation)
							cmhc_pkg::OP_LOAD: begin
								state_q <= S_LOAD;
								kind_q  <= K_LOAD;
							end
							cmhc_pkg::OP_INC, cmhc_pkg::OP_DEC, cmhc_pkg::OP_SWAP: begin
								state_q <= S_COPY;
								kind_q  <= K_MOVE;
							end
							cmhc_pkg::OP_READ: state_q <= S_READ;
							default:           state_q <= S_EMIT;
						endcase
					end
				end
				S_LOAD: state_q <= S_COPY;
				S_COPY: begin
					if (kind_q != K_MOVE) begin
						state_q <= S_SUM;
					end else if (op_q == cmhc_pkg::OP_SWAP) begin
						state_q <= S_SW1;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_SW1:   state_q <= S_SW2;
				S_SW2:   state_q <= S_SW3;
				S_SW3:   state_q <= S_SUM;
				S_APPLY: state_q <= S_SUM;
				S_SUM: begin
					if (stat.sum_done) begin
						state_q <= (kind_q == K_MOVE) ? S_REP_INIT : S_COST;
					end
				end
				S_REP_INIT: state_q <= S_REP_CHK;
				S_REP_CHK: begin
					if (!stat.rep_more) begin
						state_q <= S_COST;
					end else if (!stat.nbj_zero && !stat.val_zero) begin
						state_q <= S_REP_DIV;
					end
				end
				S_REP_DIV: begin
					if (stat.div_done) begin
						state_q <= S_REP_CHK;
					end
				end
				S_COST:   state_q <= S_DECIDE;
				S_DECIDE: state_q <= (kind_q == K_CFG) ? S_IDLE : S_EMIT;
				S_EMIT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (stat.out_free && stat.rd_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CMHC_ASSERT_NEXT(a_busy_after_take, clk, arst_n, item_valid && item_ready, !item_ready, "took a second transaction while busy")
	`CMHC_ASSERT_NOW(a_repair_needed, clk, arst_n, cmd.rep_apply, stat.rep_more, "repair applied with sum at or below target")

endmodule

@@ design/coin_mix_hill_climber.sv @@
// coin mix hill climber: one item at a time; a load rebuilds sum and cost and shows its result,
// a move also repairs, trimming coin types from the highest down (bit-serial divider);
// a readout gives one transaction per type in use (at least one), one per cycle when taken
// a register write rebuilds sum and cost with item_ready low
// asynchronous active-low reset clears counts, values, best cost and target, sets type count to one
`timescale 1ns / 1ps

module coin_mix_hill_climber (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [cmhc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cmhc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [cmhc_pkg::OP_W-1:0]           operation,
	input  logic [cmhc_pkg::IDX_W-1:0]          index_a,
	input  logic [cmhc_pkg::IDX_W-1:0]          index_b,
	input  logic [cmhc_pkg::VAL_W-1:0]          coin_value,
	input  logic [cmhc_pkg::COUNT_BITS-1:0]     start_count,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                accepted,
	output logic [cmhc_pkg::COST_W-1:0]         best_cost,
	output logic [cmhc_pkg::IDX_W-1:0]          out_index,
	output logic [cmhc_pkg::COUNT_BITS-1:0]     out_count,
	output logic                                last
);

	cmhc_pkg::dp_cmd_t  cmd;
	cmhc_pkg::dp_stat_t stat;

	cmhc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.item_valid   (item_valid),
		.operation    (operation),
		.item_ready   (item_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	cmhc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.index_a      (index_a),
		.index_b      (index_b),
		.coin_value   (coin_value),
		.start_count  (start_count),
		.cmd          (cmd),
		.stat         (stat),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.accepted     (accepted),
		.best_cost    (best_cost),
		.out_index    (out_index),
		.out_count    (out_count),
		.last         (last)
	);

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the coin mix hill climber: scoreboard class predicts
// every result from a shadow copy of counts, values and registers; needs cmhc_pkg
`timescale 1ns / 1ps

class coin_mix_scoreboard;
	logic [23:0]  target_cents;
	logic [4:0]   type_count;
	logic [15:0]  values [16];
	logic [15:0]  counts [16];
	logic [31:0]  cur_cost;
	logic [31:0]  pend_cost [$];
	logic         pend_acc [$];
	logic [3:0]   pend_idx [$];
	logic [15:0]  pend_cnt [$];
	logic         pend_last [$];
	int           errors;

	function new();
		target_cents = 0;
		type_count = 1;
		foreach (values[i]) begin
			values[i] = 0;
			counts[i] = 0;
		end
		cur_cost = 0;
		errors = 0;
	endfunction

	function int in_use();
		return (type_count > 16) ? 16 : int'(type_count);
	endfunction

	function logic [31:0] score(longint unsigned s, longint unsigned t);
		longint unsigned c;
		longint unsigned d;
		if (s == target_cents) begin
			c = t;
		end else begin
			d = (s > target_cents) ? s - target_cents : target_cents - s;
			c = 10000 + t + 10 * d;
		end
		return (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
	endfunction

	function logic [31:0] score_of(logic [15:0] c [16]);
		longint unsigned s;
		longint unsigned t;
		s = 0;
		t = 0;
		for (int i = 0; i < in_use(); i++) begin
			s += longint'(c[i]) * values[i];
			t += c[i];
		end
		return score(s, t);
	endfunction

	function void push(logic acc, logic [3:0] idx, logic [15:0] cnt, logic lst);
		pend_acc.push_back(acc);
		pend_cost.push_back(cur_cost);
		pend_idx.push_back(idx);
		pend_cnt.push_back(cnt);
		pend_last.push_back(lst);
	endfunction

	function void write_reg(logic idx, logic [23:0] data);
		if (idx == cmhc_pkg::CFG_TARGET) target_cents = data;
		else type_count = data[4:0];
		cur_cost = score_of(counts);
	endfunction

	function void note_item(logic [2:0] op, logic [3:0] a, logic [3:0] b,
			logic [15:0] val, logic [15:0] cnt);
		logic [15:0]     nb [16];
		longint unsigned s;
		longint unsigned t;
		longint unsigned ex;
		longint unsigned k;
		logic [31:0]     c;
		int              n;
		int              r;
		logic [15:0]     tmp;
		n = in_use();
		case (op)
			cmhc_pkg::OP_LOAD: begin
				values[a] = val;
				counts[a] = cnt;
				cur_cost = score_of(counts);
				push(0, 0, 0, 1);
			end
			cmhc_pkg::OP_INC, cmhc_pkg::OP_DEC, cmhc_pkg::OP_SWAP: begin
				nb = counts;
				if (op == cmhc_pkg::OP_INC) begin
					if (a < n && nb[a] != 16'hFFFF) nb[a]++;
				end else if (op == cmhc_pkg::OP_DEC) begin
					if (a < n && nb[a] != 0) nb[a]--;
				end else if (a < n && b < n && a != b) begin
					tmp = nb[a];
					nb[a] = nb[b];
					nb[b] = tmp;
				end
				s = 0;
				t = 0;
				for (int i = 0; i < n; i++) begin
					s += longint'(nb[i]) * values[i];
					t += nb[i];
				end
				// trim from the highest type while over target
				for (int j = n - 1; j >= 0 && s > target_cents; j--) begin
					if (nb[j] == 0) continue;
					if (values[j] == 0) begin
						k = nb[j];
					end else begin
						ex = s - target_cents;
						k = (ex + values[j] - 1) / values[j];
						if (k > nb[j]) k = nb[j];
					end
					nb[j] -= k[15:0];
					s -= k * values[j];
					t -= k;
				end
				c = score(s, t);
				if (c < cur_cost) begin
					counts = nb;
					cur_cost = c;
					push(1, 0, 0, 1);
				end else begin
					push(0, 0, 0, 1);
				end
			end
			cmhc_pkg::OP_READ: begin
				r = (n < 1) ? 1 : n;
				for (int i = 0; i < r; i++) push(0, i[3:0], counts[i], i == r - 1);
			end
			default: push(0, 0, 0, 1);
		endcase
	endfunction

	function void check(logic acc, logic [31:0] cost, logic [3:0] idx,
			logic [15:0] cnt, logic lst);
		if (pend_acc.size() == 0) begin
			$display("%0t unexpected result: acc %0d cost %0d idx %0d cnt %0d last %0d",
				$time, acc, cost, idx, cnt, lst);
			errors++;
			return;
		end
		if (acc !== pend_acc[0] || cost !== pend_cost[0] || idx !== pend_idx[0] ||
				cnt !== pend_cnt[0] || lst !== pend_last[0]) begin
			$display("%0t mismatch: expected acc %0d cost %0d idx %0d cnt %0d last %0d",
				$time, pend_acc[0], pend_cost[0], pend_idx[0], pend_cnt[0],
				pend_last[0]);
			$display("%0t           actual   acc %0d cost %0d idx %0d cnt %0d last %0d",
				$time, acc, cost, idx, cnt, lst);
			errors++;
		end
		void'(pend_acc.pop_front());
		void'(pend_cost.pop_front());
		void'(pend_idx.pop_front());
		void'(pend_cnt.pop_front());
		void'(pend_last.pop_front());
	endfunction
endclass

module testbench;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_write_en = 0;
	logic        cfg_index = 0;
	logic [23:0] cfg_data = 0;
	logic        item_valid = 0;
	logic        item_ready;
	logic [2:0]  operation = 0;
	logic [3:0]  index_a = 0;
	logic [3:0]  index_b = 0;
	logic [15:0] coin_value = 0;
	logic [15:0] start_count = 0;
	logic        result_valid;
	logic        result_ready = 0;
	logic        accepted;
	logic [31:0] best_cost;
	logic [3:0]  out_index;
	logic [15:0] out_count;
	logic        last;

	coin_mix_scoreboard coin_sb;
	int unsigned cycles = 0;

	always #5 clk = ~clk;

	coin_mix_hill_climber u_dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// sink: random stall per result, checked at the accepting edge
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, 4);
			if ($urandom_range(0, 3) == 0) gap = 0;
			result_ready = 0;
			repeat (gap) @(negedge clk);
			result_ready = 1;
			do @(posedge clk); while (!result_valid);
			coin_sb.check(accepted, best_cost, out_index, out_count, last);
		end
	end

	task automatic send(logic [2:0] op, logic [3:0] a, logic [3:0] b,
			logic [15:0] val, logic [15:0] cnt);
		int gap;
		gap = $urandom_range(0, 4);
		repeat (gap) @(negedge clk);
		item_valid = 1;
		operation = op;
		index_a = a;
		index_b = b;
		coin_value = val;
		start_count = cnt;
		do @(posedge clk); while (!item_ready);
		coin_sb.note_item(op, a, b, val, cnt);
		@(negedge clk);
		item_valid = 0;
	endtask

	task automatic drain();
		while (coin_sb.pend_acc.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [23:0] data);
		drain();
		cfg_write_en = 1;
		cfg_index = idx;
		cfg_data = data;
		coin_sb.write_reg(idx, data);
		@(negedge clk);
		cfg_write_en = 0;
	endtask

	task automatic rand_move(int n);
		int r;
		logic [2:0] op;
		r = $urandom_range(0, 19);
		op = (r < 7) ? cmhc_pkg::OP_INC : (r < 13) ? cmhc_pkg::OP_DEC :
			(r < 17) ? cmhc_pkg::OP_SWAP :
			(r < 19) ? cmhc_pkg::OP_READ : 3'($urandom_range(5, 7));
		send(op, (r % 5 == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1)),
			4'($urandom_range(0, n - 1)), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		int n;
		coin_sb = new();
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, all operations, saturation and special cases
		send(cmhc_pkg::OP_READ, 0, 0, 0, 0);
		write_cfg(cmhc_pkg::CFG_NUM_TYPES, 0);
		send(cmhc_pkg::OP_READ, 0, 0, 0, 0);
		send(cmhc_pkg::OP_INC, 0, 0, 0, 0);
		write_cfg(cmhc_pkg::CFG_NUM_TYPES, 31);
		write_cfg(cmhc_pkg::CFG_TARGET, 24'hFFFFFF);
		send(cmhc_pkg::OP_LOAD, 15, 0, 16'hFFFF, 16'hFFFF);
		send(cmhc_pkg::OP_INC, 15, 0, 0, 0);
		send(cmhc_pkg::OP_READ, 0, 0, 0, 0);
		write_cfg(cmhc_pkg::CFG_TARGET, 0);
		send(cmhc_pkg::OP_DEC, 15, 0, 0, 0);
		send(cmhc_pkg::OP_LOAD, 0, 0, 1, 0);
		send(cmhc_pkg::OP_DEC, 0, 0, 0, 0);
		send(cmhc_pkg::OP_LOAD, 3, 0, 0, 5);
		send(cmhc_pkg::OP_INC, 3, 0, 0, 0);
		send(cmhc_pkg::OP_SWAP, 3, 3, 0, 0);
		send(cmhc_pkg::OP_SWAP, 3, 15, 0, 0);
		send(3'd7, 0, 0, 0, 0);
		send(3'd5, 0, 0, 0, 0);
		write_cfg(cmhc_pkg::CFG_NUM_TYPES, 16);
		write_cfg(cmhc_pkg::CFG_TARGET, 123);
		send(cmhc_pkg::OP_LOAD, 1, 0, 25, 10);
		send(cmhc_pkg::OP_LOAD, 2, 0, 10, 3);
		send(cmhc_pkg::OP_INC, 1, 0, 0, 0);
		send(cmhc_pkg::OP_READ, 0, 0, 0, 0);

		// random phases with fresh registers and well-formed loads
		for (int ph = 0; ph < 6; ph++) begin
			n = (ph == 5) ? 16 : $urandom_range(1, 8);
			write_cfg(cmhc_pkg::CFG_NUM_TYPES, 24'(n));
			write_cfg(cmhc_pkg::CFG_TARGET,
				(ph == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 3000)));
			for (int i = 0; i < n && i < 6; i++)
				send(cmhc_pkg::OP_LOAD, 4'(i), 0, (i == 2 && ph == 1) ? 16'd0 :
					16'($urandom_range(1, 200)), 16'($urandom_range(0, 20)));
			for (int i = 0; i < 12; i++) rand_move(n);
		end
		drain();
		if (coin_sb.errors == 0 && coin_sb.pend_acc.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+design
design/cmhc_pkg.sv
design/cmhc_div.sv
design/cmhc_dp.sv
design/cmhc_ctrl.sv
design/coin_mix_hill_climber.sv
bench/testbench.sv
